>>> design/k_way_sorted_merge_defines.svh
// assertion macros shared by the merge block
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH
`ifndef SYNTH
`define KWSM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define KWSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KWSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KWSM_ASSERT(lbl, clk, rstn, prop)
`define KWSM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define KWSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> design/kwsm_pkg.sv
// types and constants of the k-way sorted merge
package kwsm_pkg;

    localparam int KEY_W  = 32;
    localparam int SRC_W  = 3;
    localparam int CNT_W  = 4;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_ACTIVE  = ADDR_W'(0);
    localparam logic [CNT_W-1:0]  ACTIVE_RESET = CNT_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic scan_start;
        logic scan_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic start_drain;
        logic scan_last;
        logic emit_more;
        logic emit_clear;
    } dp_status_t;

endpackage

>>> design/kwsm_in_if.sv
// input request channel of the merge block
interface kwsm_in_if;
    logic                               valid;
    logic                               ready;
    logic        [kwsm_pkg::SRC_W-1:0]  source;
    logic signed [kwsm_pkg::KEY_W-1:0]  key;
    logic                               source_last;
    logic                               source_empty;

    modport src (
        output valid, source, key, source_last, source_empty,
        input  ready
    );
    modport snk (
        input  valid, source, key, source_last, source_empty,
        output ready
    );
endinterface

>>> design/kwsm_out_if.sv
// result request channel of the merge block
interface kwsm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [kwsm_pkg::KEY_W-1:0]  merged_key;
    logic        [kwsm_pkg::SRC_W-1:0]  from_source;
    logic                               has_key;
    logic        [kwsm_pkg::SRC_W-1:0]  need_source;
    logic                               need_valid;
    logic                               run_last;
    logic                               merge_done;

    modport src (
        output valid, merged_key, from_source, has_key, need_source, need_valid,
               run_last, merge_done,
        input  ready
    );
    modport snk (
        input  valid, merged_key, from_source, has_key, need_source, need_valid,
               run_last, merge_done,
        output ready
    );
endinterface

>>> design/k_way_sorted_merge.sv
// top level of the k-way sorted merge
//
//   port     dir   kind                  moves
//   in_ch    in    valid/ready stream    one stream element per request
//   out_ch   out   valid/ready stream    one merged result per request
//   apb      in    apb write/read        active_sources at byte 0
//
// an input is taken straight from the idle state; a load that does not finish loading ends there
// each result takes a scan over every head lane (min(MAX_SOURCES, 8)) and then an
// emit, the head scan using a single shared comparator
// a new input is taken while the last result still waits in the output register
// a stalled output holds the scan in the emit state until the result is taken
// reset clears all control state; head keys are not cleared
module k_way_sorted_merge #(
    parameter int MAX_SOURCES = 8,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    kwsm_in_if.snk                               in_ch,
    kwsm_out_if.src                              out_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [kwsm_pkg::ADDR_W-1:0]   paddr,
    input  logic        [kwsm_pkg::DATA_W-1:0]   pwdata,
    output logic        [kwsm_pkg::DATA_W-1:0]   prdata,
    output logic                                 pready
);

    logic [kwsm_pkg::CNT_W-1:0] active_sources_reg;
    logic [kwsm_pkg::CNT_W-1:0] active_sources_next;
    kwsm_pkg::dp_cmd_t          cmd;
    kwsm_pkg::dp_status_t       status;

    always_comb
    begin
        active_sources_next = active_sources_reg;
        if (psel && penable && pwrite)
        begin
            active_sources_next = pwdata[kwsm_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_sources_reg <= kwsm_pkg::ACTIVE_RESET;
        end
        else
        begin
            active_sources_reg <= active_sources_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == kwsm_pkg::ADDR_ACTIVE)
                    ? kwsm_pkg::DATA_W'(active_sources_reg) : '0;

    kwsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    kwsm_dp #(
        .MAX_SOURCES (MAX_SOURCES),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_sources (active_sources_reg),
        .source         (in_ch.source),
        .key            (in_ch.key),
        .source_last    (in_ch.source_last),
        .source_empty   (in_ch.source_empty),
        .cmd            (cmd),
        .status         (status),
        .merged_key     (out_ch.merged_key),
        .from_source    (out_ch.from_source),
        .has_key        (out_ch.has_key),
        .need_source    (out_ch.need_source),
        .need_valid     (out_ch.need_valid),
        .run_last       (out_ch.run_last),
        .merge_done     (out_ch.merge_done)
    );

endmodule

>>> design/kwsm_ctrl.sv
// merge controller: accept, scan and emit sequencing
`include "k_way_sorted_merge_defines.svh"

module kwsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kwsm_pkg::dp_cmd_t    cmd,
    input  kwsm_pkg::dp_status_t status
);

    kwsm_pkg::state_t state_reg;
    kwsm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kwsm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            kwsm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.start_drain)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = kwsm_pkg::ST_SCAN;
                    end
                end
            end
            kwsm_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = kwsm_pkg::ST_EMIT;
                end
            end
            kwsm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_more)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = kwsm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = kwsm_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = kwsm_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = cmd.emit | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

    `KWSM_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, !out_valid_reg || out_ready)
    `KWSM_ASSERT_NEXT(a_drain_starts_scan, clk, rst_n, cmd.take && status.start_drain, state_reg == kwsm_pkg::ST_SCAN)
    `KWSM_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, cmd.emit, out_valid_reg)

endmodule

>>> design/kwsm_dp.sv
// merge datapath: head store, min scan and result register
`include "k_way_sorted_merge_defines.svh"

module kwsm_dp #(
    parameter int MAX_SOURCES = 8,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic        [kwsm_pkg::CNT_W-1:0]  active_sources,
    input  logic        [kwsm_pkg::SRC_W-1:0]  source,
    input  logic signed [kwsm_pkg::KEY_W-1:0]  key,
    input  logic                               source_last,
    input  logic                               source_empty,
    input  kwsm_pkg::dp_cmd_t                  cmd,
    output kwsm_pkg::dp_status_t               status,
    output logic signed [kwsm_pkg::KEY_W-1:0]  merged_key,
    output logic        [kwsm_pkg::SRC_W-1:0]  from_source,
    output logic                               has_key,
    output logic        [kwsm_pkg::SRC_W-1:0]  need_source,
    output logic                               need_valid,
    output logic                               run_last,
    output logic                               merge_done
);

    localparam int LANES = (MAX_SOURCES < 8) ? MAX_SOURCES : 8;
    localparam int LW    = $clog2(LANES);
    localparam logic [kwsm_pkg::CNT_W-1:0] LANES_C   = kwsm_pkg::CNT_W'(LANES);
    localparam logic [LW-1:0]              LAST_LANE = LW'(LANES - 1);

    logic signed [KEY_WIDTH-1:0]      head_key_mem [LANES];
    logic        [LANES-1:0]          head_full_reg, head_full_next;
    logic        [LANES-1:0]          source_done_reg, source_done_next;
    logic                             merging_reg, merging_next;
    logic        [kwsm_pkg::CNT_W-1:0] loaded_count_reg, loaded_count_next;
    logic        [LW-1:0]             scan_idx_reg, scan_idx_next;
    logic                             best_found_reg, best_found_next;
    logic        [LW-1:0]             best_idx_reg, best_idx_next;
    logic signed [KEY_WIDTH-1:0]      best_key_reg, best_key_next;

    logic signed [kwsm_pkg::KEY_W-1:0] merged_key_reg;
    logic        [kwsm_pkg::SRC_W-1:0] from_source_reg;
    logic                              has_key_reg;
    logic        [kwsm_pkg::SRC_W-1:0] need_source_reg;
    logic                              need_valid_reg;
    logic                              run_last_reg;
    logic                              merge_done_reg;

    logic        [kwsm_pkg::CNT_W-1:0] eff_count;
    logic        [kwsm_pkg::CNT_W-1:0] src_wide;
    logic        [kwsm_pkg::CNT_W-1:0] count_inc;
    logic        [LW-1:0]              lane;
    logic        [LW-1:0]              want;
    logic                              want_found;
    logic                              load_ok;
    logic                              merge_ok;
    logic                              take_ok;
    logic signed [63:0]                key_in_ext;
    logic signed [63:0]                best_ext;
    logic signed [KEY_WIDTH-1:0]       key_norm;
    logic signed [KEY_WIDTH-1:0]       head_rd;
    logic        [LANES-1:0]           best_mask;
    logic                              best_done;
    logic                              others_full;

    // stream count clamped to 1 .. lanes
    always_comb
    begin
        if (active_sources == '0)
        begin
            eff_count = kwsm_pkg::CNT_W'(1);
        end
        else if (active_sources > LANES_C)
        begin
            eff_count = LANES_C;
        end
        else
        begin
            eff_count = active_sources;
        end
    end

    // lowest stream that neither holds a head nor is finished
    always_comb
    begin
        want       = '0;
        want_found = 1'b0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (!head_full_reg[i] && !source_done_reg[i])
            begin
                want       = LW'(i);
                want_found = 1'b1;
            end
        end
    end

    assign src_wide   = kwsm_pkg::CNT_W'(source);
    assign lane       = source[LW-1:0];
    assign count_inc  = loaded_count_reg + kwsm_pkg::CNT_W'(1);
    assign key_in_ext = 64'(key);
    assign key_norm   = key_in_ext[KEY_WIDTH-1:0];
    assign best_ext   = 64'(best_key_reg);
    assign head_rd    = head_key_mem[scan_idx_reg];

    assign load_ok  = !merging_reg && (src_wide < eff_count)
                      && !head_full_reg[lane] && !source_done_reg[lane];
    assign merge_ok = merging_reg && (src_wide < LANES_C) && want_found && (want == lane);
    assign take_ok  = load_ok || merge_ok;

    assign best_mask   = LANES'(1) << best_idx_reg;
    assign best_done   = source_done_reg[best_idx_reg];
    assign others_full = |(head_full_reg & ~best_mask);

    assign status.start_drain = take_ok && (merging_reg || !(count_inc < eff_count));
    assign status.scan_last   = (scan_idx_reg == LAST_LANE);
    assign status.emit_more   = best_found_reg && best_done && others_full;
    assign status.emit_clear  = !best_found_reg || (best_done && !others_full);

    always_comb
    begin
        head_full_next    = head_full_reg;
        source_done_next  = source_done_reg;
        merging_next      = merging_reg;
        loaded_count_next = loaded_count_reg;
        scan_idx_next     = scan_idx_reg;
        best_found_next   = best_found_reg;
        best_idx_next     = best_idx_reg;
        best_key_next     = best_key_reg;

        if (cmd.take && take_ok)
        begin
            if (source_empty)
            begin
                source_done_next[lane] = 1'b1;
            end
            else
            begin
                head_full_next[lane]   = 1'b1;
                source_done_next[lane] = source_last;
            end
            if (!merging_reg)
            begin
                loaded_count_next = count_inc;
                if (!(count_inc < eff_count))
                begin
                    merging_next = 1'b1;
                end
            end
        end

        if (cmd.scan_start)
        begin
            scan_idx_next   = '0;
            best_found_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + LW'(1);
            // strict compare keeps the lower stream on ties
            if (head_full_reg[scan_idx_reg] && (!best_found_reg || (head_rd < best_key_reg)))
            begin
                best_found_next = 1'b1;
                best_idx_next   = scan_idx_reg;
                best_key_next   = head_rd;
            end
        end

        if (cmd.emit)
        begin
            if (best_found_reg)
            begin
                head_full_next[best_idx_reg] = 1'b0;
            end
            if (status.emit_clear)
            begin
                head_full_next    = '0;
                source_done_next  = '0;
                merging_next      = 1'b0;
                loaded_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_full_reg    <= '0;
            source_done_reg  <= '0;
            merging_reg      <= 1'b0;
            loaded_count_reg <= '0;
            scan_idx_reg     <= '0;
            best_found_reg   <= 1'b0;
        end
        else
        begin
            head_full_reg    <= head_full_next;
            source_done_reg  <= source_done_next;
            merging_reg      <= merging_next;
            loaded_count_reg <= loaded_count_next;
            scan_idx_reg     <= scan_idx_next;
            best_found_reg   <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        if (cmd.take && take_ok && !source_empty)
        begin
            head_key_mem[lane] <= key_norm;
        end
        if (cmd.emit)
        begin
            merged_key_reg  <= best_found_reg ? best_ext[kwsm_pkg::KEY_W-1:0] : '0;
            from_source_reg <= best_found_reg ? kwsm_pkg::SRC_W'(best_idx_reg) : '0;
            has_key_reg     <= best_found_reg;
            need_source_reg <= (best_found_reg && !best_done)
                               ? kwsm_pkg::SRC_W'(best_idx_reg) : '0;
            need_valid_reg  <= best_found_reg && !best_done;
            run_last_reg    <= !status.emit_more;
            merge_done_reg  <= status.emit_clear;
        end
    end

    assign merged_key  = merged_key_reg;
    assign from_source = from_source_reg;
    assign has_key     = has_key_reg;
    assign need_source = need_source_reg;
    assign need_valid  = need_valid_reg;
    assign run_last    = run_last_reg;
    assign merge_done  = merge_done_reg;

    `KWSM_ASSERT_IMP(a_emit_in_merge, clk, rst_n, cmd.emit, merging_reg)
    `KWSM_ASSERT_NEXT(a_clear_on_end, clk, rst_n, cmd.emit && status.emit_clear, head_full_reg == '0 && !merging_reg)
    `KWSM_ASSERT(a_count_bound, clk, rst_n, loaded_count_reg <= LANES_C)

endmodule

>>> sim/testbench.sv
// self-checking testbench of the k-way sorted merge: directed table, then random merges
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W  = kwsm_pkg::KEY_W;
    localparam int SRC_W  = kwsm_pkg::SRC_W;
    localparam int CNT_W  = kwsm_pkg::CNT_W;
    localparam int ADDR_W = kwsm_pkg::ADDR_W;
    localparam int DATA_W = kwsm_pkg::DATA_W;
    localparam logic [ADDR_W-1:0] ADDR_ACTIVE  = kwsm_pkg::ADDR_ACTIVE;
    localparam logic [CNT_W-1:0]  ACTIVE_RESET = kwsm_pkg::ACTIVE_RESET;

    localparam int LANES = 8;
    localparam int N_RAND = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [KEY_W-1:0] merged_key;
        logic [SRC_W-1:0]        from_source;
        logic                    has_key;
        logic [SRC_W-1:0]        need_source;
        logic                    need_valid;
        logic                    run_last;
        logic                    merge_done;
    } merge_res_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_NONE,
        ROW_ONE
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CNT_W-1:0]        cfg_val;
        logic [SRC_W-1:0]        source;
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    empty;
        merge_res_t              typed;
    } dir_row_t;

    localparam merge_res_t NO_RES = '0;
    localparam int N_DIR = 27;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{ROW_CFG,  4'd1,  3'd0, 32'sd0,        1'b0, 1'b0, NO_RES},
        '{ROW_NONE, 4'd0,  3'd3, 32'sd5,        1'b0, 1'b0, NO_RES},
        '{ROW_ONE,  4'd0,  3'd0, KEY_MIN,       1'b1, 1'b0,
            '{KEY_MIN, 3'd0, 1'b1, 3'd0, 1'b0, 1'b1, 1'b1}},
        '{ROW_ONE,  4'd0,  3'd0, 32'sh5a5a_a5a5, 1'b0, 1'b1,
            '{32'sd0, 3'd0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b1}},
        '{ROW_ONE,  4'd0,  3'd0, KEY_MAX,       1'b0, 1'b0,
            '{KEY_MAX, 3'd0, 1'b1, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{ROW_NONE, 4'd0,  3'd1, 32'sd7,        1'b1, 1'b0, NO_RES},
        '{ROW_ONE,  4'd0,  3'd0, KEY_MAX,       1'b1, 1'b0,
            '{KEY_MAX, 3'd0, 1'b1, 3'd0, 1'b0, 1'b1, 1'b1}},
        '{ROW_CFG,  4'd0,  3'd0, 32'sd0,        1'b0, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd0, -32'sd1,       1'b0, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd0, 32'sh1234_5678, 1'b1, 1'b1, NO_RES},
        '{ROW_CFG,  4'd3,  3'd0, 32'sd0,        1'b0, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd0, 32'sd10,       1'b0, 1'b0, NO_RES},
        '{ROW_NONE, 4'd0,  3'd0, 32'sd11,       1'b0, 1'b0, NO_RES},
        '{ROW_NONE, 4'd0,  3'd5, -32'sd3,       1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd2, 32'sd10,       1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd1, 32'sd10,       1'b0, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd0, 32'sd20,       1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd1, -32'sd1,       1'b0, 1'b1, NO_RES},
        '{ROW_CFG,  4'd15, 3'd0, 32'sd0,        1'b0, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd7, KEY_MAX,       1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd6, -32'sd1,       1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd5, 32'sd0,        1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd4, 32'sd1,        1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd3, KEY_MIN,       1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd2, 32'sd0,        1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd1, 32'sh5555_5555, 1'b1, 1'b0, NO_RES},
        '{ROW_PRED, 4'd0,  3'd0, 32'shaaaa_aaaa, 1'b1, 1'b0, NO_RES}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    kwsm_in_if  in_ch ();
    kwsm_out_if out_ch ();

    k_way_sorted_merge dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // merge state mirror
    logic signed [KEY_W-1:0] head_key    [LANES];
    logic                    head_full   [LANES];
    logic                    stream_done [LANES];
    logic                    merging;
    logic [CNT_W-1:0]        loaded_cnt;
    logic [CNT_W-1:0]        active_reg;
    bit                      fresh_merge;

    merge_res_t step_q [$];
    merge_res_t merge_exp_q [$];

    int errors;
    int send_idle_pct;
    int recv_idle_pct;

    // per-stream generator state
    int                      stream_rem    [LANES];
    bit                      stream_nolast [LANES];
    logic signed [KEY_W-1:0] stream_cur    [LANES];

    function automatic int eff_count();
        int a;
        a = active_reg;
        if (a < 1) a = 1;
        if (a > LANES) a = LANES;
        return a;
    endfunction

    function automatic int wanted_stream();
        for (int t = 0; t < LANES; t++)
        begin
            if (!head_full[t] && !stream_done[t]) return t;
        end
        return -1;
    endfunction

    function automatic void clear_merge();
        for (int t = 0; t < LANES; t++)
        begin
            head_full[t] = 1'b0;
            stream_done[t] = 1'b0;
        end
        merging = 1'b0;
        loaded_cnt = '0;
        fresh_merge = 1'b1;
    endfunction

    function automatic void push_result(logic signed [KEY_W-1:0] k, int from, logic hk,
                                        int need, logic nv, logic last, logic done);
        merge_res_t r;
        r.merged_key = k;
        r.from_source = SRC_W'(from);
        r.has_key = hk;
        r.need_source = SRC_W'(need);
        r.need_valid = nv;
        r.run_last = last;
        r.merge_done = done;
        step_q.push_back(r);
    endfunction

    function automatic void drain_heads();
        int best;
        bit any;
        forever
        begin
            best = -1;
            for (int t = 0; t < LANES; t++)
            begin
                if (head_full[t] && (best < 0 || head_key[t] < head_key[best])) best = t;
            end
            if (best < 0)
            begin
                push_result('0, 0, 1'b0, 0, 1'b0, 1'b1, 1'b1);
                clear_merge();
                return;
            end
            head_full[best] = 1'b0;
            if (!stream_done[best])
            begin
                push_result(head_key[best], best, 1'b1, best, 1'b1, 1'b1, 1'b0);
                return;
            end
            any = 1'b0;
            for (int t = 0; t < LANES; t++) any |= head_full[t];
            if (!any)
            begin
                push_result(head_key[best], best, 1'b1, 0, 1'b0, 1'b1, 1'b1);
                clear_merge();
                return;
            end
            push_result(head_key[best], best, 1'b1, 0, 1'b0, 1'b0, 1'b0);
        end
    endfunction

    function automatic void take_item(int s, logic signed [KEY_W-1:0] key, logic last,
                                      logic empty);
        if (empty)
            stream_done[s] = 1'b1;
        else
        begin
            head_key[s] = key;
            head_full[s] = 1'b1;
            stream_done[s] = last;
        end
    endfunction

    // returns 1 when the request changes the merge state
    function automatic bit predict_item(logic [SRC_W-1:0] src, logic signed [KEY_W-1:0] key,
                                        logic last, logic empty);
        int s;
        s = src;
        step_q.delete();
        if (!merging)
        begin
            if (s >= eff_count() || head_full[s] || stream_done[s]) return 1'b0;
            take_item(s, key, last, empty);
            loaded_cnt = loaded_cnt + 1'b1;
            if (loaded_cnt < eff_count()) return 1'b1;
            merging = 1'b1;
        end
        else
        begin
            if (wanted_stream() != s) return 1'b0;
            take_item(s, key, last, empty);
        end
        drain_heads();
        return 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(3))
            0: return CNT_W'($urandom_range(15));
            1: return CNT_W'($urandom_range(3, 1));
            2: return $urandom_range(1) ? 4'd1 : 4'd8;
            default: return $urandom_range(1) ? 4'd0 : 4'd15;
        endcase
    endfunction

    function automatic void check_field(string name, logic [KEY_W-1:0] exp_v,
                                        logic [KEY_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (merge_exp_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(input logic [CNT_W-1:0] val);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ACTIVE;
        pwdata <= {28'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active_reg = val;
    endtask

    task automatic send_row(input dir_row_t r, output bit taken);
        in_ch.valid <= 1'b1;
        in_ch.source <= r.source;
        in_ch.key <= r.key;
        in_ch.source_last <= r.last;
        in_ch.source_empty <= r.empty;
        do @(posedge clk); while (!in_ch.ready);
        taken = predict_item(r.source, r.key, r.last, r.empty);
        case (r.kind)
            ROW_ONE: merge_exp_q.push_back(r.typed);
            ROW_NONE: ;
            default: foreach (step_q[i]) merge_exp_q.push_back(step_q[i]);
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        merge_res_t want_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (merge_exp_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, key %0h from %0d", $time,
                         out_ch.merged_key, out_ch.from_source);
                errors++;
            end
            else
            begin
                want_res = merge_exp_q.pop_front();
                check_field("merged_key", want_res.merged_key, out_ch.merged_key);
                check_field("from_source", KEY_W'(want_res.from_source),
                            KEY_W'(out_ch.from_source));
                check_field("has_key", KEY_W'(want_res.has_key), KEY_W'(out_ch.has_key));
                check_field("need_source", KEY_W'(want_res.need_source),
                            KEY_W'(out_ch.need_source));
                check_field("need_valid", KEY_W'(want_res.need_valid),
                            KEY_W'(out_ch.need_valid));
                check_field("run_last", KEY_W'(want_res.run_last), KEY_W'(out_ch.run_last));
                check_field("merge_done", KEY_W'(want_res.merge_done),
                            KEY_W'(out_ch.merge_done));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        dir_row_t row;
        bit taken;
        bit found;
        int items_done;
        int phase;
        int s;
        int want;
        int step;
        longint nxt;

        in_ch.valid <= 1'b0;
        in_ch.source <= '0;
        in_ch.key <= '0;
        in_ch.source_last <= 1'b0;
        in_ch.source_empty <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        errors = 0;
        send_idle_pct = 35;
        recv_idle_pct = 76;
        active_reg = ACTIVE_RESET;
        clear_merge();

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_active(DIR_ROWS[i].cfg_val);
            else
                send_row(DIR_ROWS[i], taken);
        end

        items_done = 0;
        phase = 0;
        while (items_done < N_RAND)
        begin
            if (items_done * 3 / N_RAND != phase)
            begin
                phase++;
                wait_idle();
                send_idle_pct = (phase == 1) ? 76 : 0;
                recv_idle_pct = (phase == 1) ? 35 : 0;
            end

            if (fresh_merge)
            begin
                if ($urandom_range(2) == 0) write_active(pick_count());
                for (int t = 0; t < LANES; t++)
                begin
                    stream_rem[t] = ($urandom_range(5) == 0) ? 0 : int'($urandom_range(4, 1));
                    stream_nolast[t] = ($urandom_range(7) == 0);
                    case ($urandom_range(3))
                        0: stream_cur[t] = $urandom;
                        1: stream_cur[t] = $urandom_range(20);
                        2: stream_cur[t] = KEY_MIN + $urandom_range(3);
                        default: stream_cur[t] = KEY_MAX - $urandom_range(7);
                    endcase
                end
                fresh_merge = 1'b0;
            end
            else if (merging && $urandom_range(49) == 0)
                write_active(pick_count());

            // stray request that the block must drop
            if ($urandom_range(99) < 15)
            begin
                found = 1'b0;
                want = wanted_stream();
                for (int tries = 0; tries < LANES && !found; tries++)
                begin
                    s = $urandom_range(LANES - 1);
                    if (merging)
                        found = (s != want);
                    else
                        found = (s >= eff_count() || head_full[s] || stream_done[s]);
                end
                if (found)
                begin
                    row = '0;
                    row.kind = ROW_PRED;
                    row.source = SRC_W'(s);
                    row.key = $urandom;
                    row.last = 1'($urandom_range(1));
                    row.empty = 1'($urandom_range(1));
                    send_row(row, taken);
                end
            end

            if (merging)
                s = wanted_stream();
            else
            begin
                s = $urandom_range(eff_count() - 1);
                while (head_full[s] || stream_done[s]) s = (s + 1) % eff_count();
            end

            row = '0;
            row.kind = ROW_PRED;
            row.source = SRC_W'(s);
            if (stream_rem[s] == 0)
            begin
                row.empty = 1'b1;
                row.key = $urandom;
                row.last = 1'($urandom_range(1));
            end
            else
            begin
                row.key = stream_cur[s];
                stream_rem[s]--;
                row.last = (stream_rem[s] == 0) && !stream_nolast[s];
                if ($urandom_range(19) == 0)
                    stream_cur[s] = $urandom;
                else
                begin
                    step = ($urandom_range(3) == 0) ? int'($urandom_range(100000))
                                                    : int'($urandom_range(2));
                    nxt = longint'(stream_cur[s]) + longint'(step);
                    if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
                    stream_cur[s] = nxt[KEY_W-1:0];
                end
            end
            send_row(row, taken);
            if (taken) items_done++;
        end

        wait_idle();
        if (errors == 0 && merge_exp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
